@@ design/cfb_pkg.sv @@
// cfb_pkg: shared constants, the configuration struct and the byte-wide crc16 update
// for the crc16 frame builder; depends on nothing
`default_nettype none

package cfb_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_MISSION_ID  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAYLOAD_LEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_EN   = 2'd2;

  // input opcodes
  localparam logic OP_START = 1'b0;
  localparam logic OP_DATA  = 1'b1;

  // frame constants
  localparam logic [7:0]  MAX_PAYLOAD = 8'd250;
  localparam logic [7:0]  MAGIC_BYTE  = 8'hEB;
  localparam logic [7:0]  FLAG_BYTE   = 8'h00;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;

  typedef struct packed {
    logic [15:0] mission_id;
    logic [7:0]  frame_len;      // payload length, already capped
    logic        output_enable;
  } cfg_t;

  // crc16-ccitt, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

@@ design/cfb_cfg_regs.sv @@
// cfb_cfg_regs: configuration registers of the frame builder, written over the cfg channel
// depends on cfb_pkg
`default_nettype none

module cfb_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfb_pkg::CFG_DATA_W-1:0] cfg_data,
  output cfb_pkg::cfg_t                       cfg
);

  logic wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mission_id    <= 16'h0000;
      cfg.frame_len     <= 8'd0;
      cfg.output_enable <= 1'b1;
    end else if (wr) begin
      case (cfg_index)
        cfb_pkg::REG_MISSION_ID: begin
          cfg.mission_id <= cfg_data;
        end
        cfb_pkg::REG_PAYLOAD_LEN: begin
          // cap on write, same effect as capping at frame start
          cfg.frame_len <= (cfg_data[7:0] > cfb_pkg::MAX_PAYLOAD) ?
                           cfb_pkg::MAX_PAYLOAD : cfg_data[7:0];
        end
        cfb_pkg::REG_OUTPUT_EN: begin
          cfg.output_enable <= cfg_data[0];
        end
        default: begin
          // unused index, write ignored
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ design/crc16_frame_builder_unit.sv @@
// crc16_frame_builder_unit: top level of the telemetry frame builder
// depends on cfb_pkg and cfb_cfg_regs
//
//  channel  | direction | beat contents                          | handshake
//  ---------+-----------+----------------------------------------+---------------------
//  s_axis   | in        | tdata: data_byte, tuser: opcode        | tvalid / tready
//  m_axis   | out       | tdata: out_byte, tlast: frame_last     | tvalid / tready
//  cfg      | in        | cfg_index, cfg_data                    | cfg_valid / cfg_ready
//
// an accepted item goes into the item register; from there one frame byte per cycle is
// produced and loaded into the single output register, unless m_axis stalls, with the crc
// updated a byte at a time; a payload byte that does not close the frame makes only its own
// beat, so such beats stream at one per cycle unless m_axis stalls; a closing payload byte
// adds both crc bytes, a start the five header bytes (and both crc bytes for zero length)
// stalls on m_axis hold the item register and s_axis_tready; dropped bytes make no beat
// reset (rst, synchronous) closes any frame, sets crc to all ones and empties both registers
`default_nettype none

module crc16_frame_builder_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] data_byte
  input  wire logic                           s_axis_tuser,   // [0] opcode
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [7:0]                          m_axis_tdata,   // [7:0] out_byte
  output logic                                m_axis_tlast,   // frame_last
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cfb_pkg::CFG_DATA_W-1:0] cfg_data
);

  // sequencer phases
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_HDR    = 3'd1;
  localparam logic [2:0] ST_DATA   = 3'd2;
  localparam logic [2:0] ST_CRC_LO = 3'd3;
  localparam logic [2:0] ST_CRC_HI = 3'd4;

  // header byte positions
  localparam logic [2:0] HDR_MAGIC  = 3'd0;
  localparam logic [2:0] HDR_MID_LO = 3'd1;
  localparam logic [2:0] HDR_MID_HI = 3'd2;
  localparam logic [2:0] HDR_FLAGS  = 3'd3;
  localparam logic [2:0] HDR_LEN    = 3'd4;

  cfb_pkg::cfg_t cfg;

  // item register and sequencer
  logic [2:0]  state;
  logic [2:0]  state_after;
  logic [2:0]  hdr_idx;
  logic [2:0]  hdr_idx_next;
  logic [7:0]  db;

  // frame state
  logic [15:0] crc_reg;
  logic [15:0] crc_next;
  logic [7:0]  bytes_seen;
  logic [7:0]  bytes_seen_next;
  logic        frame_open;
  logic        frame_open_next;
  logic [7:0]  frame_len;
  logic [7:0]  frame_len_next;

  logic        phase_emits;
  logic [7:0]  byte_val;
  logic        last_val;
  logic        emit;
  logic        out_free;
  logic        busy;
  logic        advance;
  logic        accept;

  cfb_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // one frame byte per cycle from the current phase, unless m_axis stalls
  always_comb begin
    phase_emits     = 1'b0;
    byte_val        = 8'h00;
    last_val        = 1'b0;
    state_after     = ST_IDLE;
    hdr_idx_next    = hdr_idx;
    crc_next        = crc_reg;
    bytes_seen_next = bytes_seen;
    frame_open_next = frame_open;
    frame_len_next  = frame_len;
    case (state)
      ST_HDR: begin
        phase_emits = 1'b1;
        case (hdr_idx)
          HDR_MAGIC:  byte_val = cfb_pkg::MAGIC_BYTE;
          HDR_MID_LO: byte_val = cfg.mission_id[7:0];
          HDR_MID_HI: byte_val = cfg.mission_id[15:8];
          HDR_FLAGS:  byte_val = cfb_pkg::FLAG_BYTE;
          HDR_LEN:    byte_val = frame_len;
          default:    byte_val = 8'h00;
        endcase
        crc_next = cfb_pkg::crc16_byte((hdr_idx == HDR_MAGIC) ? cfb_pkg::CRC_INIT : crc_reg,
                                       byte_val);
        if (hdr_idx == HDR_MAGIC) begin
          // a new start drops any open frame
          bytes_seen_next = 8'd0;
          frame_open_next = 1'b1;
          frame_len_next  = cfg.frame_len;
        end
        if (hdr_idx == HDR_LEN) begin
          // zero-length frame closes straight after the header
          state_after = (frame_len == 8'd0) ? ST_CRC_LO : ST_IDLE;
        end else begin
          state_after  = ST_HDR;
          hdr_idx_next = hdr_idx + 3'd1;
        end
      end
      ST_DATA: begin
        // a byte with no frame open is dropped
        if (frame_open) begin
          phase_emits     = 1'b1;
          byte_val        = db;
          crc_next        = cfb_pkg::crc16_byte(crc_reg, db);
          bytes_seen_next = bytes_seen + 8'd1;
          state_after     = (bytes_seen_next >= frame_len) ? ST_CRC_LO : ST_IDLE;
        end
      end
      ST_CRC_LO: begin
        phase_emits = 1'b1;
        byte_val    = crc_reg[7:0];
        state_after = ST_CRC_HI;
      end
      ST_CRC_HI: begin
        phase_emits     = 1'b1;
        byte_val        = crc_reg[15:8];
        last_val        = 1'b1;
        frame_open_next = 1'b0;
        state_after     = ST_IDLE;
      end
      default: begin
        state_after = ST_IDLE;
      end
    endcase
  end

  // state advances even when output is disabled, only the beat is suppressed
  assign emit          = phase_emits && cfg.output_enable;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign busy          = (state != ST_IDLE);
  assign advance       = busy && (!emit || out_free);
  assign s_axis_tready = !busy || (advance && (state_after == ST_IDLE));
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      hdr_idx    <= HDR_MAGIC;
      crc_reg    <= cfb_pkg::CRC_INIT;
      bytes_seen <= 8'd0;
      frame_open <= 1'b0;
      frame_len  <= 8'd0;
    end else begin
      if (advance) begin
        crc_reg    <= crc_next;
        bytes_seen <= bytes_seen_next;
        frame_open <= frame_open_next;
        frame_len  <= frame_len_next;
      end
      // a new beat takes over the sequencer as the last phase of the old one ends
      if (accept) begin
        state   <= (s_axis_tuser == cfb_pkg::OP_START) ? ST_HDR : ST_DATA;
        hdr_idx <= HDR_MAGIC;
      end else if (advance) begin
        state   <= state_after;
        hdr_idx <= hdr_idx_next;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (accept) begin
      db <= s_axis_tdata;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance && emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      m_axis_tdata <= byte_val;
      m_axis_tlast <= last_val;
    end
  end

`ifndef SYNTH
  // crc trailer only ever follows an open frame
  a_crc_hi_open: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRC_HI) |-> frame_open)
    else $error("crc high byte phase with no frame open");

  // the frame closes once its crc high byte has gone
  a_close_after_crc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CRC_HI && advance) |=> !frame_open)
    else $error("frame still open after crc trailer");

  // between items an open frame still expects payload
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_IDLE || state == ST_DATA) && frame_open) |-> (bytes_seen < frame_len))
    else $error("open frame has already seen its full payload");
`endif

endmodule

`default_nettype wire
